// ----- rtl/core/mme_pkg.sv -----
// Shared types for the modular exponentiation core.
`timescale 1ns / 1ps
package mme_pkg;

  // Status of the shared multiply-reduce unit, reported to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

// ----- rtl/core/mme_if.sv -----
// Valid/ready channel interfaces for operands and results.
`timescale 1ns / 1ps
interface mme_in_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] base_value;
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;

  modport source (output valid, base_value, exponent, modulus, input ready);
  modport sink   (input valid, base_value, exponent, modulus, output ready);
endinterface

interface mme_out_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] power_result;

  modport source (output valid, power_result, input ready);
  modport sink   (input valid, power_result, output ready);
endinterface

// ----- rtl/core/mme_bit_cell.sv -----
// One cell of the multiplier operand chain: holds one bit, passes it upward.
`timescale 1ns / 1ps
module mme_bit_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic load_bit,
  input  logic prev_bit,
  output logic bit_q
);

  logic bit_r;
  logic bit_nxt;

  // Parallel load wins; otherwise take the neighbor's bit on a shift.
  always_comb begin
    bit_nxt = bit_r;
    if (load) begin
      bit_nxt = load_bit;
    end else if (shift) begin
      bit_nxt = prev_bit;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign bit_q = bit_r;

endmodule

// ----- rtl/core/mme_modmul.sv -----
// Bit-serial modular multiplier: one operand bit per cycle, MSB first.
`timescale 1ns / 1ps
module mme_modmul
  import mme_pkg::*;
#(
  parameter int W = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] b_in,
  input  logic [W-1:0] m_in,
  output mul_status_t status,
  output logic [W-1:0] product
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  a_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W-1:0]  chain;
  logic [W:0]    dbl, dbl_red, sum, sum_red;

  // Operand chain: cell 0 receives zero, the top cell feeds the adder.
  for (genvar i = 0; i < W; i++) begin : g_cell
    mme_bit_cell u_cell (
      .clk      (clk),
      .load     (start),
      .shift    (busy_r),
      .load_bit (b_in[i]),
      .prev_bit ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i-1]),
      .bit_q    (chain[i])
    );
  end

  // Doubling and conditional add, each reduced by one compare-subtract.
  always_comb begin
    dbl     = {1'b0, acc_r} + {1'b0, acc_r};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = dbl_red + {1'b0, a_r};
    sum_red = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
    acc_nxt = chain[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_in;
      m_r   <= m_in;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign product     = acc_r;

endmodule

// ----- rtl/core/modular_exponentiation_core.sv -----
// Modular exponentiation core: base^exponent mod modulus, square and multiply.
//
// Usage: an operand transfer on in_ch carries base_value, exponent and
// modulus. One result transfer on out_ch carries power_result. The block
// works on one item at a time; in_ch.ready is high only while it is idle.
// Steps: the block takes the operands, reduces the base by restoring
// division, then for each exponent bit up to the highest set one runs a
// check, one modular multiply when the bit is set and one squaring, each
// in the shared bit-serial multiplier (start, W bit steps, done), and a
// final state. The multiplier takes one operand bit per cycle.
// An exponent of zero gives 1 for any nonzero modulus; a modulus of zero gives 0.
// The result sits in an output register until taken. The next item is
// taken while that result waits; a stalled receiver then holds the block
// in its final state until the output register is free.
// Reset (synchronous, active low) clears the sequencer and output valid.
`timescale 1ns / 1ps
module modular_exponentiation_core
  import mme_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  mme_in_if.sink    in_ch,
  mme_out_if.source out_ch
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = (W > 1) ? $clog2(W) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_CHECK, S_MUL_ACC, S_MUL_SQ, S_FINISH
  } state_t;

  state_t        state_r;
  logic [W-1:0]  base_r;
  logic [W-1:0]  expo_r;
  logic [W-1:0]  mod_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  sq_r;
  logic [W-1:0]  rem_r;
  logic [CW-1:0] cnt_r;
  logic          wait_r;
  logic          out_valid_r;
  logic [W-1:0]  out_data_r;
  logic [W:0]    rem_shift, rem_nxt;
  logic          mul_start;
  logic [W-1:0]  mul_b;
  logic [W-1:0]  acc_b;
  logic [W-1:0]  product;
  mul_status_t   mul_stat;

  // One restoring division step for reducing the base.
  always_comb begin
    rem_shift = {rem_r, base_r[W-1]};
    rem_nxt   = (rem_shift >= {1'b0, mod_r}) ? rem_shift - {1'b0, mod_r} : rem_shift;
  end

  // The accumulator starts at 1, which a modulus of one reduces to 0.
  assign acc_b     = (mod_r == W'(1)) ? '0 : acc_r;
  assign mul_b     = (state_r == S_MUL_ACC) ? acc_b : sq_r;
  assign mul_start = (state_r == S_MUL_ACC || state_r == S_MUL_SQ) && !wait_r;

  mme_modmul #(.W(W)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a_in    (sq_r),
    .b_in    (mul_b),
    .m_in    (mod_r),
    .status  (mul_stat),
    .product (product)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            base_r  <= in_ch.base_value;
            expo_r  <= in_ch.exponent;
            mod_r   <= in_ch.modulus;
            acc_r   <= W'(1);
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          rem_r  <= rem_nxt[W-1:0];
          base_r <= {base_r[W-2:0], 1'b0};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CW'(W - 1)) begin
            sq_r    <= rem_nxt[W-1:0];
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (mod_r == '0) begin
            acc_r   <= '0;
            state_r <= S_FINISH;
          end else if (expo_r == '0) begin
            state_r <= S_FINISH;
          end else if (expo_r[0]) begin
            state_r <= S_MUL_ACC;
          end else begin
            state_r <= S_MUL_SQ;
          end
        end
        S_MUL_ACC: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (mul_stat.done) begin
            wait_r  <= 1'b0;
            acc_r   <= product;
            state_r <= S_MUL_SQ;
          end
        end
        S_MUL_SQ: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (mul_stat.done) begin
            wait_r  <= 1'b0;
            sq_r    <= product;
            expo_r  <= expo_r >> 1;
            state_r <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= acc_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.power_result = out_data_r;

endmodule
